// File: rtl/bois_pkg.sv
package bois_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int INDEX_W     = 24;
   localparam int BIN_W       = 12;
   localparam int PROD_W      = 2 * BIN_W;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_LAT_BINS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LON_BINS = 1'b1;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [INDEX_W-1:0] data;
   } tab_wr_type;

endpackage

// File: rtl/bois_req_if.sv
interface bois_req_if import bois_pkg::*;;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [BIN_W-1:0]   entry_address;
   logic [INDEX_W-1:0] entry_value;
   logic [INDEX_W-1:0] item_index;

   modport source (output valid, kind, entry_address, entry_value, item_index, input ready);
   modport sink   (input valid, kind, entry_address, entry_value, item_index, output ready);
endinterface

// File: rtl/bois_rsp_if.sv
interface bois_rsp_if import bois_pkg::*;;
   logic             valid;
   logic             ready;
   logic [BIN_W-1:0] lon_bin;
   logic [BIN_W-1:0] lat_bin;
   logic             out_of_range;

   modport source (output valid, lon_bin, lat_bin, out_of_range, input ready);
   modport sink   (input valid, lon_bin, lat_bin, out_of_range, output ready);
endinterface

// File: rtl/bin_of_index_search.sv
// A query runs as a chain of table probes, each passing through the multiply, table read
// and evaluate states, with one shared 12x12 multiplier and the single read port of the
// offset table; an out-of-range query ends after its first probe, against the limit entry.
// One item is in work at a time; the result is held until its transfer completes.
// Reset clears the sequencer and sets both bin counts to 1; the table is not cleared.
module bin_of_index_search import bois_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bois_req_if.sink             req,
   bois_rsp_if.source           rsp,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BIN_W-1:0]     csr_write_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_RD   = 5'b00100,
      ST_EVAL = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef enum logic [5:0] {
      SP_LIMIT  = 6'b000001,
      SP_SEARCH = 6'b000010,
      SP_HI     = 6'b000100,
      SP_SKIP0  = 6'b001000,
      SP_SKIP   = 6'b010000,
      SP_BASE   = 6'b100000
   } step_type;

   state_type           state_ff, state_in;
   step_type            step_ff, step_in;
   logic                lon_pass_ff, lon_pass_in;
   logic [INDEX_W-1:0]  key_ff, key_in;
   logic [BIN_W-1:0]    lat_cnt_ff, lon_cnt_ff;
   logic [BIN_W-1:0]    stride_ff, stride_in;
   logic [PROD_W-1:0]   base_ff, base_in;
   logic [BIN_W-1:0]    count_ff, count_in;
   logic [BIN_W-1:0]    lo_ff, lo_in;
   logic signed [BIN_W:0] hi_ff, hi_in;
   logic [BIN_W-1:0]    idx_ff, idx_in;
   logic [BIN_W-1:0]    bin_ff, bin_in;
   logic [INDEX_W-1:0]  prev_ff, prev_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [BIN_W-1:0]    lon_bin_ff, lon_bin_in;
   logic [BIN_W-1:0]    lat_bin_ff, lat_bin_in;
   logic                oor_ff, oor_in;

   logic [BIN_W-1:0]    lat_eff, lon_eff;
   logic                rd_en;
   logic [PROD_W-1:0]   rd_addr;
   logic [INDEX_W-1:0]  rd_data;
   tab_wr_type          tab_wr;

   assign lat_eff = (lat_cnt_ff == '0) ? BIN_W'(1) : lat_cnt_ff;
   assign lon_eff = (lon_cnt_ff == '0) ? BIN_W'(1) : lon_cnt_ff;

   assign prod_in = PROD_W'(stride_ff) * PROD_W'(idx_ff);
   assign rd_addr = base_ff + prod_ff;
   assign rd_en   = (state_ff == ST_RD);

   assign tab_wr.en   = req.valid && req.ready && (req.kind == KIND_WRITE);
   assign tab_wr.addr = req.entry_address[ADDR_W-1:0];
   assign tab_wr.data = req.entry_value;

   bois_table u_table (
      .clock   (clock),
      .wr      (tab_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic                  skip_go, fin_go, srch_go;
      logic [BIN_W-1:0]      skip_bin, fin_bin, srch_cnt;
      logic [BIN_W-1:0]      lo_new;
      logic signed [BIN_W:0] hi_new;
      logic signed [BIN_W+1:0] diff;
      logic [BIN_W:0]        sum;

      state_in    = state_ff;
      step_in     = step_ff;
      lon_pass_in = lon_pass_ff;
      key_in      = key_ff;
      stride_in   = stride_ff;
      base_in     = base_ff;
      count_in    = count_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      idx_in      = idx_ff;
      bin_in      = bin_ff;
      prev_in     = prev_ff;
      lon_bin_in  = lon_bin_ff;
      lat_bin_in  = lat_bin_ff;
      oor_in      = oor_ff;
      skip_go     = 1'b0;
      fin_go      = 1'b0;
      srch_go     = 1'b0;
      skip_bin    = bin_ff;
      fin_bin     = bin_ff;
      srch_cnt    = count_ff;
      lo_new      = lo_ff;
      hi_new      = hi_ff;
      diff        = '0;
      sum         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && (req.kind == KIND_QUERY)) begin
               key_in    = req.item_index;
               stride_in = lat_eff;
               idx_in    = lon_eff;
               base_in   = '0;
               step_in   = SP_LIMIT;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_RD;
         ST_RD:  state_in = ST_EVAL;
         ST_EVAL: begin
            case (step_ff)
               SP_LIMIT: begin
                  if (key_ff >= rd_data) begin
                     lon_bin_in = '0;
                     lat_bin_in = '0;
                     oor_in     = 1'b1;
                     state_in   = ST_OUT;
                  end else begin
                     lon_pass_in = 1'b1;
                     stride_in   = lat_eff;
                     base_in     = '0;
                     srch_go     = 1'b1;
                     srch_cnt    = lon_eff;
                  end
               end
               SP_SEARCH: begin
                  if (rd_data == key_ff) begin
                     skip_go  = 1'b1;
                     skip_bin = idx_ff;
                  end else begin
                     if (rd_data < key_ff) begin
                        lo_new = idx_ff;
                        hi_new = hi_ff;
                     end else begin
                        lo_new = lo_ff;
                        hi_new = $signed({1'b0, idx_ff}) - (BIN_W+1)'(1);
                     end
                     lo_in = lo_new;
                     hi_in = hi_new;
                     diff  = {hi_new[BIN_W], hi_new} - $signed({2'b00, lo_new});
                     sum   = {1'b0, lo_new} + {1'b0, hi_new[BIN_W-1:0]};
                     if (diff > (BIN_W+2)'(1)) begin
                        idx_in   = sum[BIN_W:1];
                        state_in = ST_MUL;
                     end else if (hi_new < $signed({1'b0, lo_new})) begin
                        skip_go  = 1'b1;
                        skip_bin = lo_new;
                     end else begin
                        idx_in   = hi_new[BIN_W-1:0];
                        step_in  = SP_HI;
                        state_in = ST_MUL;
                     end
                  end
               end
               SP_HI: begin
                  skip_go  = 1'b1;
                  skip_bin = (rd_data > key_ff) ? lo_ff : hi_ff[BIN_W-1:0];
               end
               SP_SKIP0: begin
                  prev_in  = rd_data;
                  idx_in   = bin_ff + BIN_W'(1);
                  step_in  = SP_SKIP;
                  state_in = ST_MUL;
               end
               SP_SKIP: begin
                  if (rd_data == prev_ff) begin
                     bin_in  = idx_ff;
                     prev_in = rd_data;
                     if (({1'b0, idx_ff} + (BIN_W+1)'(1)) < {1'b0, count_ff}) begin
                        idx_in   = idx_ff + BIN_W'(1);
                        state_in = ST_MUL;
                     end else begin
                        fin_go  = 1'b1;
                        fin_bin = idx_ff;
                     end
                  end else begin
                     fin_go  = 1'b1;
                     fin_bin = bin_ff;
                  end
               end
               SP_BASE: begin
                  base_in     = prod_ff;
                  stride_in   = BIN_W'(1);
                  lon_pass_in = 1'b0;
                  srch_go     = 1'b1;
                  srch_cnt    = lat_eff;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // advance past the search into the skip over empty bins
      if (skip_go) begin
         bin_in = skip_bin;
         if (({1'b0, skip_bin} + (BIN_W+1)'(1)) < {1'b0, count_ff}) begin
            idx_in   = skip_bin;
            step_in  = SP_SKIP0;
            state_in = ST_MUL;
         end else begin
            fin_go  = 1'b1;
            fin_bin = skip_bin;
         end
      end

      if (fin_go) begin
         if (lon_pass_ff) begin
            lon_bin_in = fin_bin;
            idx_in     = fin_bin;
            base_in    = '0;
            step_in    = SP_BASE;
            state_in   = ST_MUL;
         end else begin
            lat_bin_in = fin_bin;
            oor_in     = 1'b0;
            state_in   = ST_OUT;
         end
      end

      if (srch_go) begin
         count_in = srch_cnt;
         lo_in    = '0;
         hi_in    = $signed({1'b0, srch_cnt}) - (BIN_W+1)'(1);
         idx_in   = (srch_cnt - BIN_W'(1)) >> 1;
         step_in  = SP_SEARCH;
         state_in = ST_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= SP_LIMIT;
         lon_pass_ff <= 1'b0;
         lat_cnt_ff  <= BIN_W'(1);
         lon_cnt_ff  <= BIN_W'(1);
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         lon_pass_ff <= lon_pass_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LAT_BINS: lat_cnt_ff <= csr_write_data;
               CSR_LON_BINS: lon_cnt_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      stride_ff  <= stride_in;
      base_ff    <= base_in;
      count_ff   <= count_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      idx_ff     <= idx_in;
      bin_ff     <= bin_in;
      prev_ff    <= prev_in;
      lon_bin_ff <= lon_bin_in;
      lat_bin_ff <= lat_bin_in;
      oor_ff     <= oor_in;
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = (state_ff == ST_OUT);
   assign rsp.lon_bin      = lon_bin_ff;
   assign rsp.lat_bin      = lat_bin_ff;
   assign rsp.out_of_range = oor_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready))
      else $error("input taken while a result is pending");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.kind == KIND_QUERY)) |=> (state_ff == ST_MUL))
      else $error("query transfer did not start the sequencer");

   a_skip_in_grid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EVAL) && (step_ff == SP_SKIP)) |-> (idx_ff < count_ff))
      else $error("bin skip left the grid");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.out_of_range) |-> ((rsp.lon_bin == '0) && (rsp.lat_bin == '0)))
      else $error("out-of-range result carries bins");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.kind == KIND_WRITE)) |=> (state_ff == ST_IDLE))
      else $error("table write left the idle state");
`endif

endmodule

// File: rtl/bois_table.sv
module bois_table import bois_pkg::*; (
   input  logic               clock,
   input  tab_wr_type         wr,
   input  logic               rd_en,
   input  logic [PROD_W-1:0]  rd_addr,
   output logic [INDEX_W-1:0] rd_data
);

   logic [INDEX_W-1:0] mem [TABLE_DEPTH];
   logic [INDEX_W-1:0] q_ff;
   logic               over_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         q_ff    <= mem[rd_addr[ADDR_W-1:0]];
         over_ff <= (rd_addr >= PROD_W'(TABLE_DEPTH));
      end
   end

   // addresses past the end of the table read as zero
   assign rd_data = over_ff ? '0 : q_ff;

endmodule

// File: tb/sv/bin_of_index_search_tb.sv
`timescale 1ns / 100ps

module bin_of_index_search_tb;
   import bois_pkg::*;

   localparam int unsigned INDEX_MAX    = (1 << INDEX_W) - 1;
   localparam int          ITEM_TARGET  = 1750;
   localparam int          QUIET_CYCLES = 16;
   localparam int          REPORT_CAP   = 100;
   localparam longint      TIMEOUT_NS   = 10_000_000;

   typedef struct packed {
      logic               kind;
      logic [BIN_W-1:0]   entry_address;
      logic [INDEX_W-1:0] entry_value;
      logic [INDEX_W-1:0] item_index;
   } bin_request_type;

   typedef struct packed {
      logic [BIN_W-1:0] lon_bin;
      logic [BIN_W-1:0] lat_bin;
      logic             out_of_range;
   } bin_answer_type;

   class bin_scoreboard_type;
      logic [INDEX_W-1:0] offset_copy [TABLE_DEPTH];
      logic [BIN_W-1:0]   lat_bins_reg;
      logic [BIN_W-1:0]   lon_bins_reg;
      bin_answer_type     expected_q [$];
      int                 write_total;
      int                 query_total;
      int                 oor_total;
      int                 checked_total;

      function new();
         foreach (offset_copy[i]) offset_copy[i] = '0;
         lat_bins_reg  = BIN_W'(1);
         lon_bins_reg  = BIN_W'(1);
         write_total   = 0;
         query_total   = 0;
         oor_total     = 0;
         checked_total = 0;
      endfunction

      function void set_bin_count(logic [CSR_IDX_W-1:0] idx, logic [BIN_W-1:0] value);
         if (idx == CSR_LAT_BINS) begin
            lat_bins_reg = value;
         end else if (idx == CSR_LON_BINS) begin
            lon_bins_reg = value;
         end
      endfunction

      function int unsigned lat_bins();
         return (lat_bins_reg == 0) ? 1 : int'(lat_bins_reg);
      endfunction

      function int unsigned lon_bins();
         return (lon_bins_reg == 0) ? 1 : int'(lon_bins_reg);
      endfunction

      function int unsigned last_entry();
         return lat_bins() * lon_bins();
      endfunction

      function logic [INDEX_W-1:0] entry_at(int unsigned addr);
         if (addr < TABLE_DEPTH) return offset_copy[addr];
         return '0;
      endfunction

      // closest-below search, then advance over empty bins up to the last one
      function int unsigned closest_bin(int unsigned base, int unsigned stride,
                                        int unsigned count, logic [INDEX_W-1:0] key);
         int                 lo;
         int                 hi;
         int                 mid;
         bit                 hit;
         int unsigned        bin_sel;
         logic [INDEX_W-1:0] probe;
         lo      = 0;
         hi      = int'(count) - 1;
         hit     = 1'b0;
         bin_sel = 0;
         do begin
            mid   = (lo + hi) / 2;
            probe = entry_at(base + stride * int'(mid));
            if (probe < key) begin
               lo = mid;
            end else if (probe > key) begin
               hi = mid - 1;
            end else begin
               bin_sel = mid;
               hit     = 1'b1;
               break;
            end
         end while ((hi - lo) > 1);
         if (!hit) begin
            if (hi < lo) begin
               bin_sel = lo;
            end else if (entry_at(base + stride * int'(hi)) > key) begin
               bin_sel = lo;
            end else begin
               bin_sel = hi;
            end
         end
         while (bin_sel + 1 < count &&
                entry_at(base + stride * bin_sel) == entry_at(base + stride * (bin_sel + 1)))
            bin_sel++;
         return bin_sel;
      endfunction

      function void note_item(bin_request_type item);
         int unsigned        col;
         int unsigned        row;
         logic [INDEX_W-1:0] key;
         bin_answer_type     want;
         if (item.kind == KIND_WRITE) begin
            offset_copy[item.entry_address] = item.entry_value;
            write_total++;
            return;
         end
         query_total++;
         key = item.item_index;
         if (key >= entry_at(last_entry())) begin
            want.lon_bin      = '0;
            want.lat_bin      = '0;
            want.out_of_range = 1'b1;
            oor_total++;
         end else begin
            col = closest_bin(0, lat_bins(), lon_bins(), key);
            row = closest_bin(col * lat_bins(), 1, lat_bins(), key);
            want.lon_bin      = col[BIN_W-1:0];
            want.lat_bin      = row[BIN_W-1:0];
            want.out_of_range = 1'b0;
         end
         expected_q.push_back(want);
      endfunction

      function string check_result(bin_answer_type got);
         bin_answer_type want;
         string          msg;
         msg = "";
         if (expected_q.size() == 0)
            return $sformatf("result lon %0d lat %0d oor %0b with no query waiting",
                             got.lon_bin, got.lat_bin, got.out_of_range);
         want = expected_q.pop_front();
         checked_total++;
         if (got.lon_bin !== want.lon_bin)
            msg = {msg, $sformatf(" lon_bin %0d/%0d", got.lon_bin, want.lon_bin)};
         if (got.lat_bin !== want.lat_bin)
            msg = {msg, $sformatf(" lat_bin %0d/%0d", got.lat_bin, want.lat_bin)};
         if (got.out_of_range !== want.out_of_range)
            msg = {msg, $sformatf(" out_of_range %0b/%0b", got.out_of_range, want.out_of_range)};
         if (msg != "")
            msg = {"query result", msg, " (got/expected)"};
         return msg;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BIN_W-1:0]     csr_write_data;

   bois_req_if req_bus ();
   bois_rsp_if rsp_bus ();

   bin_scoreboard_type sb = new();

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int items_sent     = 0;
   int mismatch_count = 0;
   int setting_total  = 0;

   int unsigned demo_offsets [10] = '{10, 12, 12, 15, 15, 15, 15, 20, 25, 30};
   int unsigned demo_keys    [11] = '{0, 9, 10, 11, 12, 15, 22, 29, 30, 31, 24'hFFFFFF};

   bin_of_index_search u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d query results outstanding", sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_CAP)
         $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic bin_request_type make_write(int unsigned addr,
                                                  logic [INDEX_W-1:0] value);
      bin_request_type item;
      item.kind          = KIND_WRITE;
      item.entry_address = addr[BIN_W-1:0];
      item.entry_value   = value;
      item.item_index    = INDEX_W'($urandom_range(0, INDEX_MAX));
      return item;
   endfunction

   function automatic bin_request_type make_query(logic [INDEX_W-1:0] key);
      bin_request_type item;
      item.kind          = KIND_QUERY;
      item.entry_address = BIN_W'($urandom_range(0, TABLE_DEPTH - 1));
      item.entry_value   = INDEX_W'($urandom_range(0, INDEX_MAX));
      item.item_index    = key;
      return item;
   endfunction

   task automatic set_pacing(input int phase_no);
      case (phase_no % 4)
         0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         1: begin
            send_idle_pct = 55;
            stall_pct     = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct     = 55;
         end
         default: begin
            send_idle_pct = 26;
            stall_pct     = 26;
         end
      endcase
   endtask

   task automatic push_item(input bin_request_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= item.kind;
      req_bus.entry_address <= item.entry_address;
      req_bus.entry_value   <= item.entry_value;
      req_bus.item_index    <= item.item_index;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_item(item);
      items_sent++;
   endtask

   // drop valid, wait for every answer, then let trailing table writes land
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_bin_counts(input logic [BIN_W-1:0] lat_val,
                                   input logic [BIN_W-1:0] lon_val);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LAT_BINS;
      csr_write_data   <= lat_val;
      @(posedge clock);
      sb.set_bin_count(CSR_LAT_BINS, lat_val);
      csr_index        <= CSR_LON_BINS;
      csr_write_data   <= lon_val;
      @(posedge clock);
      sb.set_bin_count(CSR_LON_BINS, lon_val);
      csr_write_enable <= 1'b0;
      setting_total++;
   endtask

   task automatic fill_offsets(input int unsigned last_addr);
      int unsigned a;
      longint      level;
      longint      step_max;
      int unsigned empty_pct;
      bit          scramble;
      scramble  = ($urandom_range(9) == 0);
      empty_pct = $urandom_range(0, 80);
      case ($urandom_range(2))
         0:       level = 0;
         1:       level = longint'($urandom_range(0, INDEX_MAX));
         default: level = longint'($urandom_range(0, 1000));
      endcase
      case ($urandom_range(3))
         0:       step_max = 1;
         1:       step_max = 4;
         2:       step_max = 1000;
         default: step_max = 1 << 20;
      endcase
      for (a = 0; a <= last_addr; a++) begin
         if (scramble) begin
            push_item(make_write(a, INDEX_W'($urandom_range(0, INDEX_MAX))));
         end else begin
            if (a != 0 && $urandom_range(99) >= empty_pct)
               level += longint'($urandom_range(1, int'(step_max)));
            if (level > INDEX_MAX) level = INDEX_MAX;
            push_item(make_write(a, level[INDEX_W-1:0]));
         end
      end
   endtask

   function automatic logic [INDEX_W-1:0] pick_key(int unsigned last_addr);
      logic [INDEX_W-1:0] first_v;
      logic [INDEX_W-1:0] last_v;
      logic [INDEX_W-1:0] v;
      first_v = sb.entry_at(0);
      last_v  = sb.entry_at(last_addr);
      v       = sb.entry_at($urandom_range(0, last_addr));
      case ($urandom_range(9))
         0, 1, 2, 3: return v;
         4:          return v + 1'b1;
         5:          return v - 1'b1;
         6:          return (first_v != 0) ? INDEX_W'($urandom_range(0, first_v - 1)) : '0;
         7:          return $urandom_range(1) ? last_v
                                              : INDEX_W'($urandom_range(last_v, INDEX_MAX));
         8:          return INDEX_W'($urandom_range(0, INDEX_MAX));
         default:    return $urandom_range(1) ? '0 : INDEX_W'(INDEX_MAX);
      endcase
   endfunction

   task automatic run_queries(input int unsigned last_addr, input int unsigned count);
      int unsigned i;
      int unsigned addr;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1) && last_addr < TABLE_DEPTH)
               addr = $urandom_range(0, last_addr);
            else
               addr = $urandom_range(0, TABLE_DEPTH - 1);
            push_item(make_write(addr, INDEX_W'($urandom_range(0, INDEX_MAX))));
         end else begin
            push_item(make_query(pick_key(last_addr)));
         end
      end
   endtask

   initial begin : result_side
      bin_answer_type got;
      string          msg;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.lon_bin      = rsp_bus.lon_bin;
            got.lat_bin      = rsp_bus.lat_bin;
            got.out_of_range = rsp_bus.out_of_range;
            msg = sb.check_result(got);
            if (msg != "") report_mismatch(msg);
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : stimulus
      int unsigned lat_val;
      int unsigned lon_val;
      int unsigned span;
      int unsigned n_queries;
      int unsigned i;
      int          phase_no;
      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_LAT_BINS;
      csr_write_data        <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= KIND_WRITE;
      req_bus.entry_address <= '0;
      req_bus.entry_value   <= '0;
      req_bus.item_index    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // three by three grid with an empty column and empty rows
      set_pacing(0);
      write_bin_counts(BIN_W'(3), BIN_W'(3));
      for (i = 0; i < 10; i++) push_item(make_write(i, INDEX_W'(demo_offsets[i])));
      for (i = 0; i < 11; i++) push_item(make_query(INDEX_W'(demo_keys[i])));

      phase_no = 1;
      while (items_sent < ITEM_TARGET) begin
         settle();
         set_pacing(phase_no);
         case (phase_no)
            1: begin
               lat_val = 4095;
               lon_val = 4095;
            end
            2: begin
               lat_val = 0;
               lon_val = 0;
            end
            3: begin
               lat_val = 2;
               lon_val = 4095;
            end
            default: begin
               case ($urandom_range(19))
                  0, 1: begin
                     lat_val = $urandom_range(1, 64);
                     lon_val = $urandom_range(1, 4);
                  end
                  2, 3: begin
                     lat_val = $urandom_range(1, 4);
                     lon_val = $urandom_range(1, 64);
                  end
                  default: begin
                     lat_val = $urandom_range(1, 8);
                     lon_val = $urandom_range(1, 8);
                  end
               endcase
               if ($urandom_range(19) == 0) lat_val = 0;
               if ($urandom_range(19) == 0) lon_val = 0;
            end
         endcase
         write_bin_counts(BIN_W'(lat_val), BIN_W'(lon_val));
         span = sb.last_entry();
         // hold the grid inside the table; larger grids are only ever out of range
         if (span < TABLE_DEPTH) begin
            fill_offsets(span);
            n_queries = $urandom_range(20, 60);
         end else begin
            n_queries = 20;
         end
         run_queries(span, n_queries);
         phase_no++;
      end

      settle();
      repeat (40) @(posedge clock);
      if (sb.expected_q.size() != 0)
         report_mismatch($sformatf("%0d query results never arrived", sb.expected_q.size()));

      $display("Checked %0d results from %0d queries (%0d out of range) and %0d table writes",
               sb.checked_total, sb.query_total, sb.oor_total, sb.write_total);
      $display("over %0d bin-count settings, with idle and stall levels from none to 55 in 100",
               setting_total);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
